// ----- hdl/assert_macros.svh -----
// assertion macros used by the top rtl file
// each macro samples on clk_i; the module that uses them provides clk_i and rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked outside reset
`define SRTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// property checked at every edge, reset included
`define SRTI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SRTI_ASSERT(lbl, prop, msg)
`define SRTI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hdl/srti_pkg.sv -----
// shared types and constants for the sorted refcount table insert block
// no dependencies
package srti_pkg;

  // default table depth
  localparam int unsigned CAPACITY_DEF = 256;

  localparam int unsigned KEY_W     = 16;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned EXTRA_W   = 16;
  localparam int unsigned REFCNT_W  = 16;

  // result codes
  typedef enum logic [1:0] {
    STATUS_NEW      = 2'd0,
    STATUS_EXISTING = 2'd1,
    STATUS_FULL     = 2'd2
  } status_e;

  // input transaction
  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
    logic [EXTRA_W-1:0]   extra;
  } in_t;

  // output transaction
  typedef struct packed {
    logic    inserted;
    status_e status;
  } out_t;

  // one table row as stored in memory
  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
    logic [EXTRA_W-1:0]   extra;
    logic [REFCNT_W-1:0]  refcnt;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// ----- hdl/srti_ram.sv -----
// generic single write port, single read port ram with registered read data
// depends on srti_pkg for default sizes
module srti_ram #(
  parameter int unsigned WIDTH = srti_pkg::ENTRY_W,
  parameter int unsigned DEPTH = srti_pkg::CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/sorted_refcount_table_insert_top.sv -----
// Sorted refcount table insert. Each input transaction registers a resource by 16-bit key in
// a table of up to CAPACITY rows kept in ascending key order. A matching key bumps that
// row's 16-bit reference count (wrapping) and reports existing; an absent key is inserted
// with count 1 after the later rows move up one place (new), unless the table is full
// (full, nothing changes). One transaction is worked at a time: the search reads each row
// through the single read port of the table ram in S_SRCH_RD and compares it in S_SRCH_CMP,
// and the move writes one row per cycle. The block returns to S_IDLE before the next accept,
// and a result also waits in S_DONE while the previous one is still stalled in the output
// register. Input stall is high for that whole time. Table contents are not cleared at reset;
// only the row count is.
// depends on srti_pkg, srti_ram and assert_macros.svh
`include "assert_macros.svh"

module sorted_refcount_table_insert_top #(
  parameter int unsigned CAPACITY = srti_pkg::CAPACITY_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  srti_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output srti_pkg::out_t  out_data_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SRCH_RD  = 6'b000010,
    S_SRCH_CMP = 6'b000100,
    S_SHIFT    = 6'b001000,
    S_INS      = 6'b010000,
    S_DONE     = 6'b100000
  } state_e;

  state_e                 state_q, state_d;
  srti_pkg::in_t          req_q, req_d;
  logic [CNT_W-1:0]       pos_q, pos_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [CNT_W-1:0]       count_q, count_d;
  srti_pkg::status_e      status_q, status_d;
  logic                   out_valid_q, out_valid_d;
  srti_pkg::out_t         out_q, out_d;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [IDX_W-1:0]       ram_raddr;
  srti_pkg::entry_t       ram_wdata;
  logic [srti_pkg::ENTRY_W-1:0] ram_rdata;
  srti_pkg::entry_t       rd_entry;
  logic                   in_accept;
  logic                   table_full;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign rd_entry   = srti_pkg::entry_t'(ram_rdata);
  assign table_full = (count_q == CNT_W'(CAPACITY));

  // table storage
  srti_ram #(
    .WIDTH (srti_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer: linear search, then an in-place refcount bump, a top-down move and insert, an insert at the end, or full
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    count_d     = count_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q[IDX_W-1:0];
    ram_wdata   = rd_entry;
    ram_raddr   = pos_q[IDX_W-1:0];

    // output register drains independently
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          req_d   = in_data_i;
          pos_d   = '0;
          state_d = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (pos_q == count_q) begin
          if (table_full) begin
            status_d = srti_pkg::STATUS_FULL;
            state_d  = S_DONE;
          end else begin
            state_d = S_INS;
          end
        end else begin
          state_d = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (rd_entry.key < req_q.key) begin
          pos_d   = pos_q + CNT_W'(1);
          state_d = S_SRCH_RD;
        end else if (rd_entry.key == req_q.key) begin
          // bump the reference count in place
          ram_we           = 1'b1;
          ram_wdata.refcnt = rd_entry.refcnt + srti_pkg::REFCNT_W'(1);
          status_d         = srti_pkg::STATUS_EXISTING;
          state_d          = S_DONE;
        end else if (table_full) begin
          status_d = srti_pkg::STATUS_FULL;
          state_d  = S_DONE;
        end else begin
          // start the move with the last stored row
          idx_d     = IDX_W'(count_q - CNT_W'(1));
          ram_raddr = IDX_W'(count_q - CNT_W'(1));
          state_d   = S_SHIFT;
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q + IDX_W'(1);
        ram_wdata = rd_entry;
        if (idx_q == pos_q[IDX_W-1:0]) begin
          state_d = S_INS;
        end else begin
          ram_raddr = idx_q - IDX_W'(1);
          idx_d     = idx_q - IDX_W'(1);
        end
      end
      S_INS: begin
        ram_we            = 1'b1;
        ram_wdata.key     = req_q.key;
        ram_wdata.payload = req_q.payload;
        ram_wdata.extra   = req_q.extra;
        ram_wdata.refcnt  = srti_pkg::REFCNT_W'(1);
        count_d           = count_q + CNT_W'(1);
        status_d          = srti_pkg::STATUS_NEW;
        state_d           = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d    = 1'b1;
          out_d.status   = status_q;
          out_d.inserted = (status_q == srti_pkg::STATUS_NEW);
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    pos_q    <= pos_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `SRTI_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "row count above capacity")
  `SRTI_ASSERT(a_count_step, (count_q - $past(count_q)) <= CNT_W'(1), "row count jumped")
  `SRTI_ASSERT(a_busy_after_accept, in_accept |=> in_stall_o, "not busy after a transaction")
  `SRTI_ASSERT(a_shift_above_pos, state_q == S_SHIFT |-> CNT_W'(idx_q) >= pos_q, "move below pos")
  `SRTI_ASSERT_ALWAYS(a_reset_out, !rst_ni |=> !out_valid_o, "output valid after reset cycle")

endmodule
